@@ rtl/core/isb_pkg.sv @@
// Shared types and constants for the increasing-subsequence-with-breaks block.
// No dependencies; used by the controller, datapath and top level.
package isb_pkg;

    localparam int VALUE_RANGE = 1024;
    localparam int MAX_BREAKS  = 7;
    localparam int VALUE_W     = 10;
    localparam int CFG_W       = 3;
    localparam int LEN_W       = 16;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // latch an accepted word
        logic clr_wr;     // clear sweep: write zero, advance sweep counter
        logic q_init;     // set up a range-max query
        logic fin;        // query is the final whole-table read
        logic q_rd;       // present query read addresses
        logic q_step;     // fold read data into the query maxima
        logic u_init;     // form the new length, set up tree update
        logic u_rd;       // present update read addresses
        logic u_step;     // max-write and advance update indices
        logic layer_dec;  // move to the next lower break count
        logic out_load;   // load the result register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_done;
        logic q_done;
        logic u_done;
        logic layer_zero;
        logic first;
        logic last;
    } t_sts;

endpackage

@@ rtl/core/isb_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module isb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, and read registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/isb_ctrl.sv @@
// Sequencer for the increasing-subsequence-with-breaks block.
// Depends on isb_pkg (command and status structs).
module isb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  isb_pkg::t_sts i_sts,
    output isb_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_QINIT = 4'd2;
    localparam logic [3:0] S_QRD   = 4'd3;
    localparam logic [3:0] S_QWT   = 4'd4;
    localparam logic [3:0] S_UINIT = 4'd5;
    localparam logic [3:0] S_URD   = 4'd6;
    localparam logic [3:0] S_UWT   = 4'd7;
    localparam logic [3:0] S_NEXT  = 4'd8;
    localparam logic [3:0] S_FINIT = 4'd9;
    localparam logic [3:0] S_FRD   = 4'd10;
    localparam logic [3:0] S_FWT   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [3:0] r_state, n_state;
    logic       r_item, n_item;
    logic       r_out_valid, n_out_valid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_item     = 1'b1;
                    n_state    = i_sts.first ? S_CLEAR : S_QINIT;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = r_item ? S_QINIT : S_IDLE;
                end
            end
            S_QINIT: begin
                o_cmd.q_init = 1'b1;
                n_state      = S_QRD;
            end
            S_QRD: begin
                if (i_sts.q_done) begin
                    n_state = S_UINIT;
                end else begin
                    o_cmd.q_rd = 1'b1;
                    n_state    = S_QWT;
                end
            end
            S_QWT: begin
                o_cmd.q_step = 1'b1;
                n_state      = S_QRD;
            end
            S_UINIT: begin
                o_cmd.u_init = 1'b1;
                n_state      = S_URD;
            end
            S_URD: begin
                if (i_sts.u_done) begin
                    n_state = S_NEXT;
                end else begin
                    o_cmd.u_rd = 1'b1;
                    n_state    = S_UWT;
                end
            end
            S_UWT: begin
                o_cmd.u_step = 1'b1;
                n_state      = S_URD;
            end
            S_NEXT: begin
                if (!i_sts.layer_zero) begin
                    o_cmd.layer_dec = 1'b1;
                    n_state         = S_QINIT;
                end else if (i_sts.last) begin
                    n_state = S_FINIT;
                end else begin
                    n_item  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_FINIT: begin
                o_cmd.q_init = 1'b1;
                o_cmd.fin    = 1'b1;
                n_state      = S_FRD;
            end
            S_FRD: begin
                if (i_sts.q_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.q_rd = 1'b1;
                    n_state    = S_FWT;
                end
            end
            S_FWT: begin
                o_cmd.q_step = 1'b1;
                n_state      = S_FRD;
            end
            S_OUT: begin
                // wait until the output register is free
                if (!r_out_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_item         = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers; reset starts with a clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_item      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_item      <= n_item;
            r_out_valid <= n_out_valid;
        end
    end

    // a held result is never overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_ready) |=> (r_state == S_OUT))
        else $error("result overwritten while held");

    // a word flagged first always starts with a clear sweep
    a_first_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && i_sts.first) |=> (r_state == S_CLEAR))
        else $error("first word did not clear tables");

    // read data is only folded in after a read was issued
    a_qwt_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QWT) |-> ($past(r_state) == S_QRD))
        else $error("query step without read");

endmodule

@@ rtl/core/isb_dpath.sv @@
// Datapath: config register, Fenwick-tree range-max queries and updates.
// Depends on isb_pkg and isb_ram (two table memories: prefix and suffix trees).
module isb_dpath #(
    parameter int VALUE_RANGE = isb_pkg::VALUE_RANGE,
    parameter int MAX_BREAKS  = isb_pkg::MAX_BREAKS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  isb_pkg::t_cmd               i_cmd,
    output isb_pkg::t_sts               o_sts,
    input  logic [isb_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_first,
    input  logic                        i_last,
    input  logic                        i_cfg_we,
    input  logic [isb_pkg::CFG_W-1:0]   i_cfg_data,
    output logic [isb_pkg::LEN_W-1:0]   o_best_length
);

    localparam int VW    = $clog2(VALUE_RANGE);
    localparam int IW    = VW + 2;
    localparam int LW    = (MAX_BREAKS > 0) ? $clog2(MAX_BREAKS + 1) : 1;
    localparam int AW    = LW + VW;
    localparam int DEPTH = 2 ** AW;
    localparam int LEN_W = isb_pkg::LEN_W;
    localparam logic [IW-1:0] N_POS = IW'(VALUE_RANGE);

    logic [isb_pkg::CFG_W-1:0] r_break_limit;
    logic [VW-1:0]             r_v;
    logic                      r_last;
    logic [LW-1:0]             r_lim, r_layer;
    logic [IW-1:0]             r_pi, r_si;
    logic                      r_s_en;
    logic [LEN_W-1:0]          r_acc_p, r_acc_s, r_cand, r_best;
    logic [AW-1:0]             r_clr_addr;

    logic [VW-1:0]    v_in;
    logic [LW-1:0]    lim_in;
    logic [IW-1:0]    pi_low, si_low, pi_dec, si_dec, pi_inc, si_inc;
    logic [LEN_W-1:0] rd_p, rd_s, q_max, wr_p, wr_s;
    logic [AW-1:0]    addr_p, addr_s;
    logic [LW-1:0]    s_layer;
    logic             p_upd, s_upd, upd_phase;

    // input clamping
    assign v_in   = (32'(i_value) > VALUE_RANGE - 1) ? VW'(VALUE_RANGE - 1) : VW'(i_value);
    assign lim_in = (32'(r_break_limit) > MAX_BREAKS) ? LW'(MAX_BREAKS) : LW'(r_break_limit);

    // Fenwick index arithmetic: lowest set bit
    assign pi_low = r_pi & (~r_pi + IW'(1));
    assign si_low = r_si & (~r_si + IW'(1));
    assign pi_dec = r_pi - pi_low;
    assign si_dec = r_si - si_low;
    assign pi_inc = r_pi + pi_low;
    assign si_inc = r_si + si_low;

    // update positions still inside the tree
    assign p_upd = (r_pi <= N_POS);
    assign s_upd = (r_si <= N_POS);

    // memory addressing: query of the suffix tree looks one break count down
    assign upd_phase = i_cmd.u_rd | i_cmd.u_step;
    assign s_layer   = upd_phase ? r_layer : r_layer - LW'(1);
    assign addr_p    = i_cmd.clr_wr ? r_clr_addr : {r_layer, VW'(r_pi - IW'(1))};
    assign addr_s    = i_cmd.clr_wr ? r_clr_addr : {s_layer, VW'(r_si - IW'(1))};
    assign wr_p      = i_cmd.clr_wr ? '0 : ((rd_p > r_cand) ? rd_p : r_cand);
    assign wr_s      = i_cmd.clr_wr ? '0 : ((rd_s > r_cand) ? rd_s : r_cand);

    // prefix-max tree over values, one per break count
    isb_ram #(.WIDTH(LEN_W), .DEPTH(DEPTH)) u_ram_pre (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_wr | (i_cmd.u_step & p_upd)),
        .i_addr  (addr_p),
        .i_wdata (wr_p),
        .o_rdata (rd_p)
    );

    // suffix-max tree over mirrored values
    isb_ram #(.WIDTH(LEN_W), .DEPTH(DEPTH)) u_ram_suf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_wr | (i_cmd.u_step & s_upd)),
        .i_addr  (addr_s),
        .i_wdata (wr_s),
        .o_rdata (rd_s)
    );

    // new length: larger query part plus one, saturated
    assign q_max = (r_acc_p > r_acc_s) ? r_acc_p : r_acc_s;

    // config register and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_limit <= '0;
            r_clr_addr    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_break_limit <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v     <= v_in;
            r_last  <= i_last;
            r_lim   <= lim_in;
            r_layer <= lim_in;
        end
        if (i_cmd.layer_dec) begin
            r_layer <= r_layer - LW'(1);
        end
        if (i_cmd.q_init) begin
            r_acc_p <= '0;
            r_acc_s <= '0;
            if (i_cmd.fin) begin
                r_layer <= r_lim;
                r_pi    <= N_POS;
                r_si    <= '0;
                r_s_en  <= 1'b0;
            end else begin
                r_pi    <= IW'(r_v);
                r_si    <= N_POS - IW'(r_v);
                r_s_en  <= (r_layer != '0);
            end
        end
        if (i_cmd.q_step) begin
            if (r_pi != '0) begin
                if (rd_p > r_acc_p) begin
                    r_acc_p <= rd_p;
                end
                r_pi <= pi_dec;
            end
            if (r_s_en && r_si != '0) begin
                if (rd_s > r_acc_s) begin
                    r_acc_s <= rd_s;
                end
                r_si <= si_dec;
            end
        end
        if (i_cmd.u_init) begin
            r_cand <= (q_max == isb_pkg::LEN_MAX) ? q_max : q_max + LEN_W'(1);
            r_pi   <= IW'(r_v) + IW'(1);
            r_si   <= N_POS - IW'(r_v);
        end
        if (i_cmd.u_step) begin
            if (p_upd) begin
                r_pi <= pi_inc;
            end
            if (s_upd) begin
                r_si <= si_inc;
            end
        end
        if (i_cmd.out_load) begin
            r_best <= r_acc_p;
        end
    end

    assign o_sts.clr_done   = (r_clr_addr == '1);
    assign o_sts.q_done     = (r_pi == '0) && (!r_s_en || r_si == '0);
    assign o_sts.u_done     = !p_upd && !s_upd;
    assign o_sts.layer_zero = (r_layer == '0);
    assign o_sts.first      = i_first;
    assign o_sts.last       = r_last;
    assign o_best_length    = r_best;

endmodule

@@ rtl/core/increasing_subsequence_with_breaks.sv @@
// Top level: longest increasing subsequence with at most break_limit breaks.
// Depends on isb_pkg, isb_ctrl, isb_dpath (which holds two isb_ram instances).
//
// Each word carries a value, a first flag and a last flag; after a word
// flagged last one result word gives the best length for the current limit.
// Break counts are walked from the limit down to zero, and each count runs
// a Fenwick-tree prefix-max query and a suffix-max query in parallel (a read
// state, then a fold state per tree level), then a parallel max-write update
// (a read state, then a write state per level), all through single-port
// table memories. The query walks up to log2(VALUE_RANGE) levels, the update
// up to one more, and a word flagged last adds a final whole-table query.
// A word flagged first, and reset itself, runs a clearing sweep over all
// 2**(clog2(MAX_BREAKS+1) + clog2(VALUE_RANGE)) table addresses (8192 at the
// defaults) before work starts; no word is accepted during the sweep. The
// result sits in an output register so the next word can be accepted while
// it waits.
module increasing_subsequence_with_breaks #(
    parameter int VALUE_RANGE = isb_pkg::VALUE_RANGE,
    parameter int MAX_BREAKS  = isb_pkg::MAX_BREAKS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [isb_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_first,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [isb_pkg::LEN_W-1:0]   o_best_length,
    input  logic                        i_cfg_we,
    input  logic [isb_pkg::CFG_W-1:0]   i_cfg_data
);

    isb_pkg::t_cmd cmd;
    isb_pkg::t_sts sts;

    // sequencer
    isb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // tables and arithmetic
    isb_dpath #(
        .VALUE_RANGE (VALUE_RANGE),
        .MAX_BREAKS  (MAX_BREAKS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_value       (i_value),
        .i_first       (i_first),
        .i_last        (i_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_best_length (o_best_length)
    );

endmodule

@@ bench/tb_increasing_subsequence_with_breaks.sv @@
// Self-checking testbench for increasing_subsequence_with_breaks.
// Depends on isb_pkg and the block's RTL; a behavioural length-table predictor checks results.
module tb_increasing_subsequence_with_breaks;

    typedef struct packed {
        logic [isb_pkg::VALUE_W-1:0] value;
        logic                        first;
        logic                        last;
    } t_word;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic [isb_pkg::VALUE_W-1:0] i_value = '0;
    logic                        i_first = 1'b0;
    logic                        i_last = 1'b0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [isb_pkg::LEN_W-1:0]   o_best_length;
    logic                        i_cfg_we = 1'b0;
    logic [isb_pkg::CFG_W-1:0]   i_cfg_data = '0;

    increasing_subsequence_with_breaks dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_value(i_value), .i_first(i_first), .i_last(i_last),
        .o_valid(o_valid), .i_ready(i_ready), .o_best_length(o_best_length),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: one length table per break count
    logic [isb_pkg::LEN_W-1:0] len_tab [0:isb_pkg::MAX_BREAKS][0:isb_pkg::VALUE_RANGE-1];
    logic [isb_pkg::CFG_W-1:0] lim_reg;

    t_word                     word_q[$];
    logic [isb_pkg::LEN_W-1:0] best_len_q[$];
    int               n_fail = 0;
    int               n_words = 0;
    int               n_results = 0;
    int               send_idle = 0;   // percent of cycles the sender idles
    int               recv_stall = 0;  // percent of cycles the receiver stalls
    longint           cycles = 0;

    function automatic void clear_tables();
        foreach (len_tab[t, u]) len_tab[t][u] = '0;
    endfunction

    // Fold one word into the tables; queue the best length when flagged last
    function automatic void predict_word(t_word w);
        int          lim;
        int          v;
        int          j;
        int          best;
        int          cand;
        logic [isb_pkg::LEN_W-1:0] mx;
        lim = (lim_reg > isb_pkg::MAX_BREAKS) ? isb_pkg::MAX_BREAKS : lim_reg;
        v = w.value;
        if (v > isb_pkg::VALUE_RANGE - 1) v = isb_pkg::VALUE_RANGE - 1;
        if (w.first) clear_tables();
        for (j = lim; j >= 0; j--) begin
            best = 0;
            for (int u = 0; u < v; u++)
                if (len_tab[j][u] > best) best = len_tab[j][u];
            if (j > 0)
                for (int u = v; u < isb_pkg::VALUE_RANGE; u++)
                    if (len_tab[j-1][u] > best) best = len_tab[j-1][u];
            cand = best + 1;
            if (cand > isb_pkg::LEN_MAX) cand = isb_pkg::LEN_MAX;
            if (cand > len_tab[j][v]) len_tab[j][v] = cand[isb_pkg::LEN_W-1:0];
        end
        if (w.last) begin
            mx = '0;
            for (int u = 0; u < isb_pkg::VALUE_RANGE; u++)
                if (len_tab[lim][u] > mx) mx = len_tab[lim][u];
            best_len_q.push_back(mx);
        end
    endfunction

    // Driver: present queued words, predict on acceptance
    always @(posedge i_clk) begin
        t_word nxt;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                nxt.value = i_value;
                nxt.first = i_first;
                nxt.last  = i_last;
                predict_word(nxt);
                n_words++;
                void'(word_q.pop_front());
            end
            if (!i_valid || o_ready) begin
                if ((word_q.size() > 0) && $urandom_range(99) >= send_idle) begin
                    nxt = word_q[0];
                    i_valid <= 1'b1;
                    i_value <= nxt.value;
                    i_first <= nxt.first;
                    i_last  <= nxt.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (best_len_q.size() == 0) begin
                    $error("unexpected result word: best_length=%0d", o_best_length);
                    n_fail++;
                end else begin
                    if (o_best_length !== best_len_q[0]) begin
                        $error("best_length: expected %0d, actual %0d",
                               best_len_q[0], o_best_length);
                        n_fail++;
                    end
                    void'(best_len_q.pop_front());
                    n_results++;
                end
            end
            i_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 40000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push(int v, bit f, bit l);
        t_word w;
        w.value = v[isb_pkg::VALUE_W-1:0];
        w.first = f;
        w.last  = l;
        word_q.push_back(w);
    endtask

    task automatic drain();
        wait (word_q.size() == 0);
        @(posedge i_clk);
        wait (word_q.size() == 0 && !i_valid && best_len_q.size() == 0);
        // trailing words without last may still be in flight
        repeat (800) @(posedge i_clk);
    endtask

    task automatic set_limit(int lim);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= lim[isb_pkg::CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lim_reg = lim[isb_pkg::CFG_W-1:0];
    endtask

    // Random sequences: short runs, mostly rising with some dips
    task automatic rand_seqs(int n_items);
        int k;
        int len;
        int v;
        k = 0;
        while (k < n_items) begin
            len = $urandom_range(12, 1);
            v = $urandom_range(isb_pkg::VALUE_RANGE - 1);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(9))
                    0, 1:    v = $urandom_range(isb_pkg::VALUE_RANGE - 1);
                    2:       v = (v > 5) ? v - $urandom_range(5) : v;
                    3:       v = v;
                    default: v = (v < isb_pkg::VALUE_RANGE - 9) ? v + $urandom_range(8, 1)
                                                                : $urandom_range(20);
                endcase
                // an occasional missing first flag keeps the old sequence going
                push(v, (i == 0) && ($urandom_range(9) != 0), i == len - 1);
                k++;
            end
        end
    endtask

    initial begin
        lim_reg = '0;
        clear_tables();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        i_ready <= 1'b1;

        // Directed: limit 0, extremes of value, repeats, flags
        push(0, 1, 0); push(1023, 0, 0); push(1023, 0, 1);
        push(512, 0, 1);           // continue without first
        push(1023, 1, 1);          // single word sequence
        drain();
        set_limit(7);
        push(5, 1, 0); push(5, 0, 0); push(4, 0, 0); push(3, 0, 0);
        push(0, 0, 0); push(1023, 0, 0); push(1023, 0, 0); push(0, 0, 1);
        push(682, 0, 0); push(341, 0, 1);
        drain();
        set_limit(2);              // tables above the new limit stand as they are
        push(100, 0, 0); push(50, 0, 1);
        push(9, 1, 0); push(8, 0, 0); push(7, 0, 0); push(6, 0, 1);
        drain();

        // Random phases across idling patterns and limits
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 83; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 83; end
                3: begin send_idle = 34; recv_stall = 34; end
            endcase
            set_limit((ph == 0) ? 0 : (ph == 7) ? 7 : $urandom_range(7));
            rand_seqs(105);
            drain();
        end

        $display("Run covered %0d words and %0d result words over limits 0 to 7,",
                 n_words, n_results);
        $display("with sender idling and receiver stalling phases.");
        if (n_fail == 0 && best_len_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/isb_pkg.sv
rtl/core/isb_ram.sv
rtl/core/isb_ctrl.sv
rtl/core/isb_dpath.sv
rtl/core/increasing_subsequence_with_breaks.sv
bench/tb_increasing_subsequence_with_breaks.sv
